FILE: src/delimited_text_field_tokenizer_assert.svh
// ----------------------------------------------------------------------------
// Tokenizer assertion macros
// Clocked property wrappers shared by the checker.
// ----------------------------------------------------------------------------
`ifndef DELIMITED_TEXT_FIELD_TOKENIZER_ASSERT_SVH
`define DELIMITED_TEXT_FIELD_TOKENIZER_ASSERT_SVH

// implication checked in the same cycle
`define DTFT_ASSERT_NOW(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) else $error(msg);

// implication checked in the next cycle
`define DTFT_ASSERT_NEXT(label, clk, rst_n, a, b, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) else $error(msg);

`endif

FILE: src/dtft_pkg.sv
// ----------------------------------------------------------------------------
// Tokenizer package
// Shared constants, types and character helpers.
// ----------------------------------------------------------------------------
package dtft_pkg;

	localparam int BlankDepth = 32;
	localparam int BlankAw    = $clog2(BlankDepth);
	localparam int BlankCw    = $clog2(BlankDepth + 1);

	localparam logic [8:0] CH_EOF = 9'h100;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_BSL = 8'h5C;
	localparam logic [7:0] CH_BEL = 8'h07;
	localparam logic [7:0] CH_BS  = 8'h08;
	localparam logic [7:0] CH_FF  = 8'h0C;
	localparam logic [7:0] CH_VT  = 8'h0B;
	localparam logic [7:0] CH_D0  = 8'h30;
	localparam logic [7:0] CH_D8  = 8'h38;
	localparam logic [7:0] CH_LA  = 8'h61;
	localparam logic [7:0] CH_LB  = 8'h62;
	localparam logic [7:0] CH_LF_N = 8'h6E;
	localparam logic [7:0] CH_LR  = 8'h72;
	localparam logic [7:0] CH_LT  = 8'h74;
	localparam logic [7:0] CH_LV  = 8'h76;
	localparam logic [7:0] CH_LFF = 8'h66;
	localparam logic [7:0] CH_LX  = 8'h78;

	localparam logic [2:0] REG_SEP     = 3'd0;
	localparam logic [2:0] REG_QUOTE1  = 3'd1;
	localparam logic [2:0] REG_QUOTE2  = 3'd2;
	localparam logic [2:0] REG_COMMENT = 3'd3;
	localparam logic [2:0] REG_ESC     = 3'd4;
	localparam logic [2:0] REG_STRIP   = 3'd5;
	localparam logic [2:0] REG_TEXT    = 3'd6;

	localparam logic [1:0] CAUSE_GAP = 2'd0;
	localparam logic [1:0] CAUSE_LF  = 2'd1;
	localparam logic [1:0] CAUSE_CR  = 2'd2;
	localparam logic [1:0] CAUSE_EOF = 2'd3;

	typedef enum logic [7:0] {
		PH_START   = 8'b0000_0001,
		PH_W_QUOTE = 8'b0000_0010,
		PH_W_QBS   = 8'b0000_0100,
		PH_W_WORD  = 8'b0000_1000,
		PH_W_AFTER = 8'b0001_0000,
		PH_S_BODY  = 8'b0010_0000,
		PH_S_QUOTE = 8'b0100_0000,
		PH_S_QCLOSE = 8'b1000_0000
	} phase_t;

	typedef enum logic [6:0] {
		ES_NONE    = 7'b000_0001,
		ES_COMMENT = 7'b000_0010,
		ES_BSL     = 7'b000_0100,
		ES_OCT1    = 7'b000_1000,
		ES_OCT2    = 7'b001_0000,
		ES_HEX0    = 7'b010_0000,
		ES_HEX1    = 7'b100_0000
	} esc_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_STEP  = 5'b00010,
		S_FL_RD = 5'b00100,
		S_FL_EM = 5'b01000,
		S_FIN   = 5'b10000
	} ctrl_state_t;

	typedef struct packed {
		logic [7:0] data;
		logic       kind;
		logic [1:0] cause;
		logic       quoted;
	} result_t;

	typedef struct packed {
		logic accept;
		logic raw_ready;
		logic eof_taken;
		logic step_go;
		logic fl_rd;
		logic fl_em;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic src_none;
		logic src_raw;
		logic raw_eof;
		logic need_flush;
		logic emits;
		logic half;
		logic stream_end;
		logic can_emit;
		logic pend_v;
		logic out_free;
		logic flush_last;
	} dp_status_t;

	function automatic logic is_blank(input logic [8:0] c);
		return !c[8] && (c[7:0] == CH_SP || c[7:0] == CH_TAB);
	endfunction

	function automatic logic is_space(input logic [8:0] c);
		return is_blank(c) || (!c[8] && (c[7:0] == CH_LF || c[7:0] == CH_CR));
	endfunction

	function automatic logic is_line_end(input logic [8:0] c);
		return c[8] || c[7:0] == CH_LF || c[7:0] == CH_CR;
	endfunction

	function automatic logic [1:0] cause_of(input logic [8:0] c);
		if (c[8])
			return CAUSE_EOF;
		else if (c[7:0] == CH_LF)
			return CAUSE_LF;
		else if (c[7:0] == CH_CR)
			return CAUSE_CR;
		else
			return CAUSE_GAP;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_val(input logic [8:0] c);
		logic [7:0] b;
		b = c[7:0];
		if (c[8])
			return 5'd0;
		else if (b >= 8'h30 && b <= 8'h39)
			return {1'b1, b[3:0]};
		else if ((b >= 8'h41 && b <= 8'h46) || (b >= 8'h61 && b <= 8'h66))
			return {1'b1, 4'(b[3:0] + 4'd9)};
		else
			return 5'd0;
	endfunction

endpackage

FILE: src/dtft_ctrl.sv
// ----------------------------------------------------------------------------
// Tokenizer controller
// Sequences one input byte through character steps and blank flushes.
// ----------------------------------------------------------------------------
module dtft_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  dtft_pkg::dp_status_t st,
	output dtft_pkg::dp_cmd_t    cmd
);
	import dtft_pkg::*;

	ctrl_state_t state_q;
	logic        raw_ready_q;
	logic        eof_taken_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd           = '0;
		cmd.raw_ready = raw_ready_q;
		cmd.eof_taken = eof_taken_q;
		cmd.accept    = in_valid && in_ready;
		case (state_q)
			S_STEP: begin
				if (!st.src_none && !st.need_flush && (!st.emits || st.can_emit))
					cmd.step_go = 1'b1;
			end
			S_FL_RD: cmd.fl_rd = 1'b1;
			S_FL_EM: cmd.fl_em = st.can_emit;
			S_FIN:   cmd.finish = st.pend_v && st.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			raw_ready_q <= 1'b0;
			eof_taken_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd.accept) begin
						raw_ready_q <= 1'b1;
						eof_taken_q <= 1'b0;
						state_q     <= S_STEP;
					end
				end
				S_STEP: begin
					if (st.src_none) begin
						state_q <= S_FIN;
					end else if (st.need_flush) begin
						state_q <= S_FL_RD;
					end else if (cmd.step_go && !st.half) begin
						if (st.stream_end) begin
							raw_ready_q <= 1'b0;
							eof_taken_q <= 1'b0;
							state_q     <= S_FIN;
						end else if (st.src_raw) begin
							raw_ready_q <= 1'b0;
							eof_taken_q <= st.raw_eof;
						end
					end
				end
				S_FL_RD: state_q <= S_FL_EM;
				S_FL_EM: begin
					if (cmd.fl_em)
						state_q <= st.flush_last ? S_STEP : S_FL_RD;
				end
				S_FIN: begin
					if (!st.pend_v || st.out_free)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: src/dtft_dp.sv
// ----------------------------------------------------------------------------
// Tokenizer datapath
// Parse state, escape decode, blank buffer and result output stage.
// ----------------------------------------------------------------------------
module dtft_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [7:0]           in_byte,
	input  logic                 end_of_input,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [8:0]           cfg_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [7:0]           out_byte,
	output logic                 out_kind,
	output logic [1:0]           end_cause,
	output logic                 field_quoted,
	output logic                 last,
	input  dtft_pkg::dp_cmd_t    cmd,
	output dtft_pkg::dp_status_t st
);
	import dtft_pkg::*;

	// configuration
	logic [7:0] sep_q, q1_q, q2_q;
	logic [8:0] comment_q;
	logic       esc_on_q, strip_q, text_q;

	// parse state
	phase_t             ph_q, n_ph;
	esc_t               es_q, n_es;
	logic [7:0]         ev_q, n_ev;
	logic [8:0]         held_q, n_held;
	logic               held_v_q, n_held_v;
	logic [7:0]         oq_q, n_oq;
	logic               fs_q, n_fs, qs_q, n_qs;
	logic [BlankCw-1:0] bc_q, n_bc;
	logic               bs_done_q;
	logic [8:0]         raw_q;

	logic [7:0]         blank_mem [BlankDepth];
	logic [7:0]         rdata_q;
	logic [BlankAw-1:0] ptr_q;

	result_t pend_q, out_q, em_r;
	logic    pend_v_q, out_v_q, last_q;

	logic       src_held, src_none, em, push, flush_rq, end3, half, commit;
	logic [8:0] x, cc;

	function automatic logic is_q(input logic [8:0] c, input logic [7:0] a,
			input logic [7:0] b);
		return !c[8] && c[7:0] != 8'd0 && (c[7:0] == a || c[7:0] == b);
	endfunction

	always_comb begin
		logic       do_c, dig, inq, sb, end_rq;
		logic [4:0] hv;
		logic [7:0] vt;
		logic [1:0] ecause;

		src_held = (es_q == ES_NONE) && held_v_q;
		if (src_held)
			x = held_q;
		else if (cmd.raw_ready)
			x = raw_q;
		else
			x = CH_EOF;
		src_none = !src_held && !cmd.raw_ready && !cmd.eof_taken;

		n_ph = ph_q; n_es = es_q; n_ev = ev_q; n_held = held_q;
		n_held_v = src_held ? 1'b0 : held_v_q;
		n_oq = oq_q; n_fs = fs_q; n_qs = qs_q; n_bc = bc_q;
		em = 1'b0; em_r = '0; push = 1'b0; flush_rq = 1'b0; end3 = 1'b0;
		half = 1'b0; do_c = 1'b0; cc = x; sb = 1'b0; end_rq = 1'b0;
		ecause = CAUSE_GAP; vt = 8'd0;
		inq = (ph_q == PH_W_QUOTE) || (ph_q == PH_W_QBS) || (ph_q == PH_S_QUOTE) ||
			(ph_q == PH_S_QCLOSE);
		dig = !x[8] && x[7:0] >= CH_D0 && x[7:0] <= CH_D8;
		hv  = hex_val(x);

		// front end: comments and escapes
		if (es_q == ES_NONE) begin
			if (!x[8] && !comment_q[8] && x[7:0] == comment_q[7:0] && !inq)
				n_es = ES_COMMENT;
			else if (x == {1'b0, CH_BSL} && esc_on_q)
				n_es = ES_BSL;
			else
				do_c = 1'b1;
		end else begin
			n_es = ES_NONE;
			case (es_q)
				ES_COMMENT: begin
					if (x == {1'b0, CH_LF} || x[8])
						do_c = 1'b1;
					else
						n_es = ES_COMMENT;
				end
				ES_BSL: begin
					if (dig) begin
						n_ev = {4'd0, x[3:0]};
						n_es = ES_OCT1;
					end else begin
						do_c = 1'b1;
						case (x)
							{1'b0, CH_LA}:   cc = {1'b0, CH_BEL};
							{1'b0, CH_LB}:   cc = {1'b0, CH_BS};
							{1'b0, CH_LFF}:  cc = {1'b0, CH_FF};
							{1'b0, CH_LF_N}: cc = {1'b0, CH_LF};
							{1'b0, CH_LR}:   cc = {1'b0, CH_CR};
							{1'b0, CH_LT}:   cc = {1'b0, CH_TAB};
							{1'b0, CH_LV}:   cc = {1'b0, CH_VT};
							{1'b0, CH_LX}: begin
								do_c = 1'b0;
								n_ev = 8'd0;
								n_es = ES_HEX0;
							end
							default: begin
								if (inq && is_q(x, q1_q, q2_q)) begin
									n_held = x; n_held_v = 1'b1;
									cc = {1'b0, CH_BSL};
								end
							end
						endcase
					end
				end
				ES_OCT1, ES_OCT2: begin
					if (dig) begin
						vt = {ev_q[4:0], 3'b000} + {4'd0, x[3:0]};
						n_ev = vt;
						if (es_q == ES_OCT1) n_es = ES_OCT2;
						else begin do_c = 1'b1; cc = {1'b0, vt}; end
					end else begin
						n_held = x; n_held_v = 1'b1;
						do_c = 1'b1; cc = {1'b0, ev_q};
					end
				end
				default: begin
					if (hv[4]) begin
						vt = {ev_q[3:0], hv[3:0]};
						n_ev = vt;
						if (es_q == ES_HEX0) n_es = ES_HEX1;
						else begin do_c = 1'b1; cc = {1'b0, vt}; end
					end else begin
						n_held = x; n_held_v = 1'b1;
						do_c = 1'b1; cc = {1'b0, ev_q};
					end
				end
			endcase
		end

		// field parser
		if (do_c) begin
			case (ph_q)
				PH_START: begin
					if (sep_q != 8'd0) begin
						sb = 1'b1;
					end else if (is_blank(cc)) begin
						n_ph = ph_q;
					end else if (is_line_end(cc)) begin
						end_rq = 1'b1; ecause = cause_of(cc);
					end else if (text_q && is_q(cc, q1_q, q2_q)) begin
						n_oq = cc[7:0]; n_qs = 1'b1; n_ph = PH_W_QUOTE;
					end else begin
						em = 1'b1; em_r.data = cc[7:0]; n_ph = PH_W_WORD;
					end
				end
				PH_W_QUOTE: begin
					if (cc[8]) begin
						end_rq = 1'b1; ecause = CAUSE_EOF;
					end else if (cc[7:0] == oq_q)
						n_ph = PH_W_AFTER;
					else if (cc[7:0] == CH_BSL)
						n_ph = PH_W_QBS;
					else begin
						em = 1'b1; em_r.data = cc[7:0];
					end
				end
				PH_W_QBS: begin
					if (cc[8]) begin
						end_rq = 1'b1; ecause = CAUSE_EOF;
					end else if (cc[7:0] != oq_q && !bs_done_q) begin
						// backslash goes out first, the byte on the next pass
						em = 1'b1; em_r.data = CH_BSL; half = 1'b1;
					end else begin
						em = 1'b1; em_r.data = cc[7:0]; n_ph = PH_W_QUOTE;
					end
				end
				PH_W_WORD: begin
					if (is_blank(cc))
						n_ph = PH_W_AFTER;
					else if (is_line_end(cc)) begin
						end_rq = 1'b1; ecause = cause_of(cc);
					end else begin
						em = 1'b1; em_r.data = cc[7:0];
					end
				end
				PH_W_AFTER: begin
					if (is_blank(cc))
						n_ph = ph_q;
					else if (is_line_end(cc)) begin
						end_rq = 1'b1; ecause = cause_of(cc);
					end else begin
						n_held = cc; n_held_v = 1'b1;
						end_rq = 1'b1; ecause = CAUSE_GAP;
					end
				end
				PH_S_QUOTE: begin
					if (cc[8]) begin
						end_rq = 1'b1; ecause = CAUSE_EOF;
					end else if (cc[7:0] == oq_q)
						n_ph = PH_S_QCLOSE;
					else begin
						em = 1'b1; em_r.data = cc[7:0]; n_fs = 1'b1;
					end
				end
				PH_S_QCLOSE: begin
					if (!cc[8] && cc[7:0] == oq_q) begin
						em = 1'b1; em_r.data = cc[7:0]; n_fs = 1'b1; n_ph = PH_S_QUOTE;
					end else if ((!cc[8] && cc[7:0] == sep_q) || is_line_end(cc)) begin
						end_rq = 1'b1; ecause = cause_of(cc);
					end else begin
						n_held = cc; n_held_v = 1'b1; n_ph = PH_S_BODY;
					end
				end
				default: sb = 1'b1;
			endcase
		end

		// separator-mode body
		if (sb) begin
			if ((!cc[8] && cc[7:0] == sep_q) || is_line_end(cc)) begin
				end_rq = 1'b1; ecause = cause_of(cc);
			end else begin
				n_ph = PH_S_BODY;
				if (!text_q && is_blank(cc)) begin
					n_ph = PH_S_BODY;
				end else if (text_q && is_q(cc, q1_q, q2_q)) begin
					flush_rq = 1'b1;
					n_oq = cc[7:0]; n_qs = 1'b1; n_ph = PH_S_QUOTE;
				end else if (strip_q && is_space(cc)) begin
					if (fs_q) begin
						if (bc_q >= BlankCw'(BlankDepth)) flush_rq = 1'b1;
						push = 1'b1;
						n_bc = bc_q + 1'b1;
					end
				end else begin
					flush_rq = 1'b1;
					em = 1'b1; em_r.data = cc[7:0]; n_fs = 1'b1;
				end
			end
		end

		if (end_rq) begin
			n_bc = '0;
			em = 1'b1;
			em_r.data = 8'd0; em_r.kind = 1'b1; em_r.cause = ecause; em_r.quoted = qs_q;
			n_fs = 1'b0; n_qs = 1'b0; n_ph = PH_START;
			end3 = (ecause == CAUSE_EOF);
		end
	end

	assign commit = cmd.step_go && !half;

	always_comb begin
		st            = '0;
		st.src_none   = src_none;
		st.src_raw    = !src_held && cmd.raw_ready;
		st.raw_eof    = raw_q[8];
		st.need_flush = flush_rq && (bc_q != '0);
		st.emits      = em;
		st.half       = half;
		st.stream_end = end3;
		st.out_free   = !out_v_q || out_ready;
		st.can_emit   = !pend_v_q || st.out_free;
		st.pend_v     = pend_v_q;
		st.flush_last = (BlankCw'(ptr_q) + 1'b1) == bc_q;
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q     <= 8'd0;
			q1_q      <= 8'd34;
			q2_q      <= 8'd39;
			comment_q <= 9'd256;
			esc_on_q  <= 1'b0;
			strip_q   <= 1'b0;
			text_q    <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SEP:     sep_q     <= cfg_data[7:0];
				REG_QUOTE1:  q1_q      <= cfg_data[7:0];
				REG_QUOTE2:  q2_q      <= cfg_data[7:0];
				REG_COMMENT: comment_q <= cfg_data;
				REG_ESC:     esc_on_q  <= cfg_data[0];
				REG_STRIP:   strip_q   <= cfg_data[0];
				REG_TEXT:    text_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// parse state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_START; es_q <= ES_NONE; ev_q <= 8'd0;
			held_q <= CH_EOF; held_v_q <= 1'b0; oq_q <= 8'd0;
			fs_q <= 1'b0; qs_q <= 1'b0; bc_q <= '0; bs_done_q <= 1'b0;
			ptr_q <= '0;
		end else begin
			if (commit) begin
				bs_done_q <= 1'b0;
				if (end3) begin
					ph_q <= PH_START; es_q <= ES_NONE; ev_q <= 8'd0;
					held_v_q <= 1'b0; oq_q <= 8'd0;
					fs_q <= 1'b0; qs_q <= 1'b0; bc_q <= '0;
				end else begin
					ph_q <= n_ph; es_q <= n_es; ev_q <= n_ev;
					held_q <= n_held; held_v_q <= n_held_v; oq_q <= n_oq;
					fs_q <= n_fs; qs_q <= n_qs; bc_q <= n_bc;
				end
			end else if (cmd.step_go) begin
				bs_done_q <= 1'b1;
			end
			if (cmd.fl_em) begin
				if (st.flush_last) begin
					ptr_q <= '0;
					bc_q  <= '0;
				end else begin
					ptr_q <= ptr_q + 1'b1;
				end
			end
		end
	end

	// the pushed blank is the character the parser saw
	always_ff @(posedge clk) begin
		if (cmd.accept)
			raw_q <= end_of_input ? CH_EOF : {1'b0, in_byte};
		if (commit && push)
			blank_mem[bc_q[BlankAw-1:0]] <= cc[7:0];
		if (cmd.fl_rd)
			rdata_q <= blank_mem[ptr_q];
	end

	// result buffer: one result held back so the last flag is known
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && out_ready)
				out_v_q <= 1'b0;
			if ((cmd.step_go && em) || cmd.fl_em) begin
				if (pend_v_q)
					out_v_q <= 1'b1;
				pend_v_q <= 1'b1;
			end
			if (cmd.finish) begin
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.step_go && em) || cmd.fl_em) begin
			if (pend_v_q) begin
				out_q  <= pend_q;
				last_q <= 1'b0;
			end
			if (cmd.fl_em)
				pend_q <= '{data: rdata_q, kind: 1'b0, cause: CAUSE_GAP, quoted: 1'b0};
			else
				pend_q <= em_r;
		end
		if (cmd.finish) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign out_valid    = out_v_q;
	assign out_byte     = out_q.data;
	assign out_kind     = out_q.kind;
	assign end_cause    = out_q.cause;
	assign field_quoted = out_q.quoted;
	assign last         = last_q;

endmodule

FILE: src/delimited_text_field_tokenizer.sv
// ----------------------------------------------------------------------------
// Delimited text field tokenizer
// Splits a raw byte stream into field content bytes and end-of-field marks.
// ----------------------------------------------------------------------------
// One input transfer carries a text byte or the end-of-input mark; the block
// answers with zero or more result transfers (content bytes, end-of-field
// marks) with last set on the final one of that input. Inputs are handled one
// at a time: after its transfer a byte goes through its character steps (a
// held-back character adds a step, a backslash kept inside a whitespace-mode
// quote adds one), a step that finds the byte used up (skipped after end of
// input) and a final state that hands over the last result. Each flush of
// the blank buffer passes through a read state and an emit state for every
// buffered trailing blank; a stalled output stretches any step that emits.
// The blank buffer holds 32 bytes in a memory read through a registered
// port, hence the separate read state of a flush.
// Configuration writes are accepted every cycle and must only happen while
// the block is idle.
module delimited_text_field_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       end_of_input,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_kind,
	output logic [1:0] end_cause,
	output logic       field_quoted,
	output logic       last,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [8:0] cfg_data
);
	import dtft_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t st;

	// register writes never stall
	assign cfg_ready = 1'b1;

	// controller: walks each input through its character steps
	dtft_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: parse state, blank buffer, result stage
	dtft_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (in_byte),
		.end_of_input (end_of_input),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_byte     (out_byte),
		.out_kind     (out_kind),
		.end_cause    (end_cause),
		.field_quoted (field_quoted),
		.last         (last),
		.cmd          (cmd),
		.st           (st)
	);

endmodule

FILE: src/dtft_checker.sv
// ----------------------------------------------------------------------------
// Tokenizer port checker
// Port-level properties, bound to the top level.
// ----------------------------------------------------------------------------
`include "delimited_text_field_tokenizer_assert.svh"

module dtft_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_kind,
	input logic [1:0] end_cause,
	input logic       field_quoted,
	input logic       cfg_ready
);
	import dtft_pkg::*;

	`DTFT_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`DTFT_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready, "input taken while busy")
	`DTFT_ASSERT_NOW(a_mark_zero, clk, arst_n, out_valid && out_kind, out_byte == 8'd0, "end mark with data")
	`DTFT_ASSERT_NOW(a_content_clean, clk, arst_n, out_valid && !out_kind, end_cause == CAUSE_GAP && !field_quoted && cfg_ready, "content with end info")

endmodule

bind delimited_text_field_tokenizer dtft_checker u_dtft_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_byte     (out_byte),
	.out_kind     (out_kind),
	.end_cause    (end_cause),
	.field_quoted (field_quoted),
	.cfg_ready    (cfg_ready)
);

FILE: bench/tb_delimited_text_field_tokenizer.sv
// ----------------------------------------------------------------------------
// Tokenizer testbench
// Feeds text bytes and end-of-input marks through several register settings,
// predicts every field byte and end-of-field mark, and checks the outputs.
// ----------------------------------------------------------------------------
module tb_delimited_text_field_tokenizer;
	timeunit 1ns;
	timeprecision 1ps;

	import dtft_pkg::*;

	localparam int HoldLimit = 600000;   // cycles before the run is declared hung
	localparam int DrainWait = 120;      // covers a full blank-buffer flush
	localparam int StepCap   = 36;       // most results one byte can cause

	typedef struct {
		logic [7:0] b;
		logic       eoi;
	} text_item_t;

	typedef struct packed {
		logic [7:0] b;
		logic       kind;
		logic [1:0] cause;
		logic       quoted;
		logic       lst;
	} token_t;

	logic       clk, arst_n;
	logic       in_valid, in_ready, end_of_input;
	logic [7:0] in_byte;
	logic       out_valid, out_ready;
	logic [7:0] out_byte;
	logic       out_kind, field_quoted, last;
	logic [1:0] end_cause;
	logic       cfg_valid, cfg_ready;
	logic [2:0] cfg_index;
	logic [8:0] cfg_data;

	delimited_text_field_tokenizer uut (.*);

	// stimulus and expectation stores
	text_item_t text_q[$];
	token_t     step_toks[$];
	token_t     token_q[$];
	bit         in_taken;
	bit         no_idle;
	int         mismatches, tokens_seen, bytes_sent, cyc;

	// ---------------- token predictor ----------------
	// register copies
	logic [7:0] sep, q1, q2;
	logic [8:0] cmt;
	logic       esc_on, strip, txt;
	// parser state
	phase_t     ph;
	esc_t       es;
	logic [7:0] esc_val;
	int         held;          // -1 when nothing held back
	int         oq;
	bit         started, qseen, done;
	logic [7:0] blanks[BlankDepth];
	int         nblank;

	function void put(int b, bit k, logic [1:0] c, bit q);
		token_t t;
		t = '{b: b[7:0], kind: k, cause: c, quoted: q, lst: 1'b0};
		if (step_toks.size() < StepCap)
			step_toks.push_back(t);
	endfunction

	function bit blank_c(int c);
		return c == CH_SP || c == CH_TAB;
	endfunction

	function bit space_c(int c);
		return blank_c(c) || c == CH_LF || c == CH_CR;
	endfunction

	function bit line_end(int c);
		return c == CH_LF || c == CH_CR || c == CH_EOF;
	endfunction

	function bit quote_c(int c);
		return c != 0 && c < 256 && (c == q1 || c == q2);
	endfunction

	function bit quoted_phase();
		return ph inside {PH_W_QUOTE, PH_W_QBS, PH_S_QUOTE, PH_S_QCLOSE};
	endfunction

	function logic [1:0] cause_for(int c);
		if (c == CH_EOF) return CAUSE_EOF;
		if (c == CH_LF) return CAUSE_LF;
		if (c == CH_CR) return CAUSE_CR;
		return CAUSE_GAP;
	endfunction

	function void clear_parser();
		ph = PH_START; es = ES_NONE; esc_val = 0; held = -1; oq = 0;
		started = 0; qseen = 0; nblank = 0;
	endfunction

	function void flush_held_blanks();
		for (int i = 0; i < nblank; i++)
			put(blanks[i], 0, CAUSE_GAP, 0);
		nblank = 0;
	endfunction

	function void close_field(logic [1:0] c);
		nblank = 0;
		put(0, 1, c, qseen);
		started = 0; qseen = 0; ph = PH_START;
		if (c == CAUSE_EOF)
			done = 1;
	endfunction

	function bit ends_sep(int c);
		return (c < 256 && c == sep) || line_end(c);
	endfunction

	function void sep_body(int c);
		if (ends_sep(c)) begin
			close_field(cause_for(c));
			return;
		end
		ph = PH_S_BODY;
		if (!txt && blank_c(c))
			return;
		if (txt && quote_c(c)) begin
			flush_held_blanks();
			oq = c; qseen = 1; ph = PH_S_QUOTE;
			return;
		end
		if (strip && space_c(c)) begin
			if (!started)
				return;
			// overflow: held blanks go out unstripped
			if (nblank >= BlankDepth)
				flush_held_blanks();
			blanks[nblank] = c[7:0];
			nblank++;
			return;
		end
		flush_held_blanks();
		put(c, 0, CAUSE_GAP, 0);
		started = 1;
	endfunction

	function void ws_lead(int c);
		if (blank_c(c))
			return;
		if (line_end(c)) begin
			close_field(cause_for(c));
			return;
		end
		if (txt && quote_c(c)) begin
			oq = c; qseen = 1; ph = PH_W_QUOTE;
			return;
		end
		put(c, 0, CAUSE_GAP, 0);
		ph = PH_W_WORD;
	endfunction

	function void parse_char(int c);
		case (ph)
			PH_START: begin
				if (sep == 0) ws_lead(c);
				else sep_body(c);
			end
			PH_W_QUOTE: begin
				if (c == CH_EOF) close_field(CAUSE_EOF);
				else if (c == oq) ph = PH_W_AFTER;
				else if (c == CH_BSL) ph = PH_W_QBS;
				else put(c, 0, CAUSE_GAP, 0);
			end
			PH_W_QBS: begin
				if (c == CH_EOF)
					close_field(CAUSE_EOF);
				else begin
					// backslash kept unless it hides the own quote
					if (c != oq) put(CH_BSL, 0, CAUSE_GAP, 0);
					put(c, 0, CAUSE_GAP, 0);
					ph = PH_W_QUOTE;
				end
			end
			PH_W_WORD: begin
				if (blank_c(c)) ph = PH_W_AFTER;
				else if (line_end(c)) close_field(cause_for(c));
				else put(c, 0, CAUSE_GAP, 0);
			end
			PH_W_AFTER: begin
				if (blank_c(c)) ;
				else if (line_end(c)) close_field(cause_for(c));
				else begin
					held = c;
					close_field(CAUSE_GAP);
				end
			end
			PH_S_QUOTE: begin
				if (c == CH_EOF) close_field(CAUSE_EOF);
				else if (c == oq) ph = PH_S_QCLOSE;
				else begin
					put(c, 0, CAUSE_GAP, 0);
					started = 1;
				end
			end
			PH_S_QCLOSE: begin
				if (c == oq) begin
					// doubled quote
					put(c, 0, CAUSE_GAP, 0);
					started = 1;
					ph = PH_S_QUOTE;
				end else if (ends_sep(c))
					close_field(cause_for(c));
				else begin
					held = c;
					ph = PH_S_BODY;
				end
			end
			default: sep_body(c);
		endcase
	endfunction

	function void front_char(int c);
		if (c < 256 && cmt < 256 && c == cmt && !quoted_phase()) begin
			es = ES_COMMENT;
			return;
		end
		if (c == CH_BSL && esc_on) begin
			es = ES_BSL;
			return;
		end
		parse_char(c);
	endfunction

	function int hex_digit(int c);
		if (c >= "0" && c <= "9") return c - "0";
		if (c >= "A" && c <= "F") return c - "A" + 10;
		if (c >= "a" && c <= "f") return c - "a" + 10;
		return -1;
	endfunction

	function void escape_char(int r);
		bit   digit;
		int   h;
		esc_t prev;
		digit = r >= CH_D0 && r <= CH_D8;
		h = hex_digit(r);
		prev = es;
		es = ES_NONE;
		case (prev)
			ES_COMMENT: begin
				if (r == CH_LF || r == CH_EOF) parse_char(r);
				else es = ES_COMMENT;
			end
			ES_BSL: begin
				if (digit) begin
					esc_val = 8'(r - CH_D0);
					es = ES_OCT1;
				end else if (r == CH_LA) parse_char(CH_BEL);
				else if (r == CH_LB) parse_char(CH_BS);
				else if (r == CH_LFF) parse_char(CH_FF);
				else if (r == CH_LF_N) parse_char(CH_LF);
				else if (r == CH_LR) parse_char(CH_CR);
				else if (r == CH_LT) parse_char(CH_TAB);
				else if (r == CH_LV) parse_char(CH_VT);
				else if (r == CH_LX) begin
					esc_val = 0;
					es = ES_HEX0;
				end else if (quoted_phase() && quote_c(r)) begin
					held = r;
					parse_char(CH_BSL);
				end else
					parse_char(r);
			end
			ES_OCT1, ES_OCT2: begin
				if (digit) begin
					esc_val = 8'(esc_val * 8 + (r - CH_D0));
					if (prev == ES_OCT1) es = ES_OCT2;
					else parse_char(esc_val);
				end else begin
					held = r;
					parse_char(esc_val);
				end
			end
			default: begin
				if (h >= 0) begin
					esc_val = 8'(esc_val * 16 + h);
					if (prev == ES_HEX0) es = ES_HEX1;
					else parse_char(esc_val);
				end else begin
					held = r;
					parse_char(esc_val);
				end
			end
		endcase
	endfunction

	// one accepted input: append its tokens to the expectation store
	function void predict_tokens(text_item_t it);
		int  raw, x;
		bit  raw_left, eof_seen;
		raw = it.eoi ? int'(CH_EOF) : int'(it.b);
		raw_left = 1; eof_seen = 0; done = 0;
		step_toks.delete();
		for (int g = 0; g < 64 && !done; g++) begin
			if (es == ES_NONE && held >= 0) begin
				x = held;
				held = -1;
				front_char(x);
				continue;
			end
			if (raw_left) begin
				raw_left = 0;
				x = raw;
				if (x == CH_EOF) eof_seen = 1;
			end else if (eof_seen)
				x = CH_EOF;
			else
				break;
			if (es != ES_NONE) escape_char(x);
			else front_char(x);
		end
		if (done)
			clear_parser();
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].lst = 1;
		foreach (step_toks[i])
			token_q.push_back(step_toks[i]);
	endfunction

	// ---------------- clock, reset, watchdog ----------------
	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > HoldLimit) begin
			$display("timeout at %0t with %0d tokens still expected", $time, token_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// ---------------- monitor: input acceptance and result check ----------------
	always @(posedge clk) begin
		token_t w;
		in_taken = in_valid && in_ready;
		if (in_taken) begin
			predict_tokens('{b: in_byte, eoi: end_of_input});
			bytes_sent++;
		end
		if (out_valid && out_ready) begin
			tokens_seen++;
			if (token_q.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected token byte=%02h kind=%0b cause=%0d q=%0b last=%0b",
					$time, out_byte, out_kind, end_cause, field_quoted, last);
			end else begin
				w = token_q.pop_front();
				if (out_byte !== w.b || out_kind !== w.kind || end_cause !== w.cause ||
						field_quoted !== w.quoted || last !== w.lst) begin
					mismatches++;
					$display("%0t: expected byte=%02h kind=%0b cause=%0d q=%0b last=%0b",
						$time, w.b, w.kind, w.cause, w.quoted, w.lst);
					$display("%0t:   actual byte=%02h kind=%0b cause=%0d q=%0b last=%0b",
						$time, out_byte, out_kind, end_cause, field_quoted, last);
				end
			end
		end
	end

	// ---------------- driver: inputs change on the falling edge ----------------
	always @(negedge clk) begin
		text_item_t it;
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 99) >= 18);
			// a held transfer keeps valid and payload until taken
			if (!in_valid || in_taken) begin
				if (text_q.size() > 0 && (no_idle || $urandom_range(0, 99) >= 18)) begin
					it = text_q.pop_front();
					in_valid <= 1'b1;
					in_byte <= it.b;
					end_of_input <= it.eoi;
				end else
					in_valid <= 1'b0;
			end
		end
	end

	// ---------------- stimulus ----------------
	task automatic write_reg(logic [2:0] idx, logic [8:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_SEP:     sep = val[7:0];
			REG_QUOTE1:  q1 = val[7:0];
			REG_QUOTE2:  q2 = val[7:0];
			REG_COMMENT: cmt = val;
			REG_ESC:     esc_on = val[0];
			REG_STRIP:   strip = val[0];
			default:     txt = val[0];
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic setup(int s, int a, int b, int c, int e, int st, int t);
		write_reg(REG_SEP, 9'(s));
		write_reg(REG_QUOTE1, 9'(a));
		write_reg(REG_QUOTE2, 9'(b));
		write_reg(REG_COMMENT, 9'(c));
		write_reg(REG_ESC, 9'(e));
		write_reg(REG_STRIP, 9'(st));
		write_reg(REG_TEXT, 9'(t));
	endtask

	task automatic push_byte(int b);
		text_q.push_back('{b: b[7:0], eoi: 1'b0});
	endtask

	task automatic push_eoi();
		text_q.push_back('{b: 8'($urandom_range(0, 255)), eoi: 1'b1});
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endtask

	// weighted toward the bytes that steer the parser
	function automatic int pick_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 26) return $urandom_range("a", "z");
		if (r < 36) return $urandom_range("0", "9");
		if (r < 48) return $urandom_range(0, 1) ? CH_SP : CH_TAB;
		if (r < 54) return $urandom_range(0, 1) ? CH_LF : CH_CR;
		if (r < 62) return (sep != 0) ? int'(sep) : int'(CH_SP);
		if (r < 70) return $urandom_range(0, 1) ? int'(q1) : int'(q2);
		if (r < 78) return CH_BSL;
		if (r < 82) return $urandom_range(0, 1) ? CH_LX : CH_LF_N;
		if (r < 85) return (cmt < 256) ? int'(cmt[7:0]) : int'(CH_LA);
		if (r < 92) return $urandom_range(0, 255);
		return $urandom_range("A", "F");
	endfunction

	task automatic push_random(int n);
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(0, 99);
			if (r < 2)
				push_eoi();
			else if (r < 4 && strip) begin
				// long blank run, which can overflow the buffer
				push_byte("k");
				repeat ($urandom_range(30, 36)) push_byte(CH_SP);
			end else
				push_byte(pick_byte());
		end
		push_eoi();
	endtask

	// wait until every transfer is taken and every token checked
	task automatic drain();
		do @(posedge clk); while (text_q.size() > 0 || in_valid || token_q.size() > 0);
		repeat (DrainWait) @(posedge clk);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; in_byte = '0; end_of_input = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		no_idle = 0; cyc = 0; mismatches = 0; tokens_seen = 0; bytes_sent = 0;
		sep = 0; q1 = 8'd34; q2 = 8'd39; cmt = 9'd256; esc_on = 0; strip = 0; txt = 1;
		clear_parser();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset values: whitespace mode, backslash-quote inside a quote
		push_text("ab \"c\\\"d\" x\n");
		push_byte(0);
		push_byte(255);
		push_eoi();
		push_random(65);
		drain();

		// CSV with comments, escapes and stripping; no idling here
		setup(",", 34, 39, "#", 1, 1, 1);
		no_idle = 1;
		push_text(" a ,\"x\"\"y\"#c\n\\x4g\\101\\8\\t\\a\\b\\f\\v\\r,");
		push_random(65);
		drain();
		no_idle = 0;

		// numeric fields, extreme quote and comment values
		setup(";", 255, 0, 0, 1, 0, 0);
		push_random(65);
		drain();

		setup(255, 0, "|", 255, 0, 1, 1);
		push_random(65);
		drain();

		// whitespace mode with escapes and comments
		setup(0, 39, 34, "#", 1, 0, 1);
		push_random(65);
		drain();

		$display("checked %0d tokens from %0d input transfers over five register settings",
			tokens_seen, bytes_sent);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
